// ===== src/leb_pkg.sv =====
// Shared types and constants for the line edit buffer.
// No dependencies; every other file of the block but leb_ram imports this package.
package leb_pkg;

    localparam int LINE_DEPTH_DEF = 64;

    // Reset values of the character-code registers.
    localparam logic [7:0] ERASE_RST = 8'd35;
    localparam logic [7:0] KILL_RST  = 8'd64;
    localparam logic [7:0] STOP_RST  = 8'd36;
    localparam logic [7:0] END_RST   = 8'd10;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ERASE = 2'd0;
    localparam logic [1:0] REG_KILL  = 2'd1;
    localparam logic [1:0] REG_STOP  = 2'd2;
    localparam logic [1:0] REG_END   = 2'd3;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_ERASE,
        OP_KILL,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_cmd;

    // Status of the back end, seen by the top level.
    typedef struct packed {
        logic draining;
        logic full;
        logic empty;
    } t_back_stat;

endpackage

// ===== src/leb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/leb_front.sv =====
// Front end: accepts characters, classifies them against the code registers
// and tracks the stop and halt status. Depends on leb_pkg.
module leb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_erase_char,
    input  logic [7:0]    i_kill_char,
    input  logic [7:0]    i_stop_char,
    input  logic [7:0]    i_end_char,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    output logic          o_ready,
    output logic          o_cmd_valid,
    output leb_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    import leb_pkg::*;

    logic r_stop_seen;
    logic r_halted;
    logic w_accept;
    logic w_is_stop;
    t_op  w_op;

    // End wins over erase, erase over kill, kill over stop.
    always_comb begin
        w_is_stop = 1'b0;
        priority if (i_char == i_end_char) begin
            w_op = OP_END;
        end else if (i_char == i_erase_char) begin
            w_op = OP_ERASE;
        end else if (i_char == i_kill_char) begin
            w_op = OP_KILL;
        end else if (i_char == i_stop_char) begin
            w_op      = OP_PUSH;
            w_is_stop = 1'b1;
        end else begin
            w_op = OP_PUSH;
        end
    end

    assign o_ready     = i_cmd_ready;
    assign w_accept    = i_valid && i_cmd_ready;
    assign o_cmd_valid = w_accept && !r_halted && !w_is_stop;
    assign o_cmd.op    = w_op;
    assign o_cmd.ch    = i_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_seen <= 1'b0;
            r_halted    <= 1'b0;
        end else if (w_accept && !r_halted) begin
            if (w_is_stop) begin
                r_stop_seen <= 1'b1;
            end else if (w_op == OP_END) begin
                r_halted    <= r_stop_seen;
                r_stop_seen <= 1'b0;
            end
        end
    end

endmodule

// ===== src/leb_fifo.sv =====
// Short command queue between front and back ends.
// Depends on leb_pkg.
module leb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    input  leb_pkg::t_cmd i_wr_cmd,
    output logic          o_wr_ready,
    output logic          o_rd_valid,
    output leb_pkg::t_cmd o_rd_cmd,
    input  logic          i_rd_ready
);
    import leb_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_wr_ready = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QUEUE_AW + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

// ===== src/leb_back.sv =====
// Back end: executes queued commands on the line store and drains a line
// to the output stream. Depends on leb_pkg and leb_ram.
module leb_back #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  leb_pkg::t_cmd       i_cmd,
    output logic                o_cmd_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_char,
    output logic                o_last,
    output logic                o_trunc,
    output leb_pkg::t_back_stat o_stat
);
    import leb_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    typedef enum logic {
        ST_EXEC,
        ST_DRAIN
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_fill;
    logic          r_ovf;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic          r_trunc;
    logic          r_rd_vld;
    logic          r_rd_last;
    logic          r_rd_trunc;
    logic          r_out_vld;
    logic [7:0]    r_out_char;
    logic          r_out_last;
    logic          r_out_trunc;

    logic          w_pop;
    logic          w_full;
    logic          w_move;
    logic          w_issue;
    logic          w_we;
    logic [CW-1:0] w_idx_next;
    logic [7:0]    w_rdata;

    assign o_cmd_ready = (r_state == ST_EXEC);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_full      = (r_fill == CW'(LINE_DEPTH));
    assign w_we        = w_pop && (i_cmd.op == OP_PUSH) && !w_full;
    // The RAM read register is a pipeline stage; it moves on when the
    // output register is free or being taken.
    assign w_move      = r_rd_vld && (!r_out_vld || i_ready);
    assign w_issue     = (r_state == ST_DRAIN) && (!r_rd_vld || w_move);
    assign w_idx_next  = r_idx + CW'(1);

    leb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_cmd.ch),
        .i_re    (w_issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_EXEC;
            r_fill    <= '0;
            r_ovf     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                ST_EXEC: begin
                    if (w_pop) begin
                        unique case (i_cmd.op)
                            OP_PUSH: begin
                                if (w_full) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_fill <= r_fill + CW'(1);
                                end
                            end
                            OP_ERASE: begin
                                if (r_fill != '0) begin
                                    r_fill <= r_fill - CW'(1);
                                end
                            end
                            OP_KILL: begin
                                r_fill <= '0;
                                r_ovf  <= 1'b0;
                            end
                            OP_END: begin
                                r_cnt   <= r_fill;
                                r_trunc <= r_ovf;
                                r_idx   <= '0;
                                r_fill  <= '0;
                                r_ovf   <= 1'b0;
                                if (r_fill != '0) begin
                                    r_state <= ST_DRAIN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DRAIN: begin
                    if (w_issue) begin
                        r_idx <= w_idx_next;
                        if (w_idx_next == r_cnt) begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                default: begin
                    r_state <= ST_EXEC;
                end
            endcase

            if (w_issue) begin
                r_rd_vld   <= 1'b1;
                r_rd_last  <= (w_idx_next == r_cnt);
                r_rd_trunc <= r_trunc;
            end else if (w_move) begin
                r_rd_vld <= 1'b0;
            end

            if (w_move) begin
                r_out_vld   <= 1'b1;
                r_out_char  <= w_rdata;
                r_out_last  <= r_rd_last;
                r_out_trunc <= r_rd_trunc;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;
    assign o_trunc = r_out_trunc;

    assign o_stat.draining = (r_state == ST_DRAIN);
    assign o_stat.full     = w_full;
    assign o_stat.empty    = (r_fill == '0);

endmodule

// ===== src/line_edit_buffer_top.sv =====
// Top level of the line edit buffer: configuration registers and the
// front end, command queue and back end. Depends on leb_pkg and all leb_ modules.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         s_axis_tvalid/tready      tdata[7:0] = in_char
//  m_axis    out        m_axis_tvalid/tready      tdata[7:0] = out_char,
//                                                 tlast = line_last,
//                                                 tuser = line_truncated
//  apb       in         psel/penable, pready = 1  four 8-bit code registers
//
// A character is classified and queued in the cycle it is accepted; while the four-entry
// command queue has room, one request is taken every cycle. An end-of-line with stored
// characters holds the back end for the drain, one line-store read per cycle while m_axis
// is not stalled; each character reaches m_axis through the line-store read register and
// the output register. A stalled m_axis backs up into the drain, then the queue, then
// s_axis. Reset is synchronous and active low; only entries below the fill count are ever read.
module line_edit_buffer_top #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] line_truncated
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import leb_pkg::*;

    logic [7:0] r_erase_char;
    logic [7:0] r_kill_char;
    logic [7:0] r_stop_char;
    logic [7:0] r_end_char;
    logic [1:0] w_reg_idx;
    logic       w_cfg_wr;

    t_cmd       w_front_cmd;
    logic       w_front_valid;
    logic       w_front_ready;
    t_cmd       w_cmd;
    logic       w_cmd_valid;
    logic       w_cmd_ready;
    t_back_stat w_stat;

    // Registers sit at byte addresses 0, 4, 8 and 12; the low address bits
    // do not take part in decoding.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_char <= ERASE_RST;
            r_kill_char  <= KILL_RST;
            r_stop_char  <= STOP_RST;
            r_end_char   <= END_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_ERASE: r_erase_char <= pwdata[7:0];
                REG_KILL:  r_kill_char  <= pwdata[7:0];
                REG_STOP:  r_stop_char  <= pwdata[7:0];
                REG_END:   r_end_char   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_ERASE: prdata = {24'd0, r_erase_char};
            REG_KILL:  prdata = {24'd0, r_kill_char};
            REG_STOP:  prdata = {24'd0, r_stop_char};
            REG_END:   prdata = {24'd0, r_end_char};
            default:   prdata = '0;
        endcase
    end

    // The front end classifies each character; stop characters and anything
    // after the session has ended never reach the queue.
    leb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_erase_char (r_erase_char),
        .i_kill_char  (r_kill_char),
        .i_stop_char  (r_stop_char),
        .i_end_char   (r_end_char),
        .i_valid      (s_axis_tvalid),
        .i_char       (s_axis_tdata),
        .o_ready      (s_axis_tready),
        .o_cmd_valid  (w_front_valid),
        .o_cmd        (w_front_cmd),
        .i_cmd_ready  (w_front_ready)
    );

    leb_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .i_wr_cmd   (w_front_cmd),
        .o_wr_ready (w_front_ready),
        .o_rd_valid (w_cmd_valid),
        .o_rd_cmd   (w_cmd),
        .i_rd_ready (w_cmd_ready)
    );

    // The back end owns the line store, the fill count and the overflow flag.
    leb_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_trunc     (m_axis_tuser),
        .o_stat      (w_stat)
    );

`ifndef ASSERT_OFF
    // No command leaves the queue while a line is being drained.
    a_no_pop_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.draining |-> !w_cmd_ready)
        else $error("command taken during line drain");

    // Storing a character into a line with room leaves the line non-empty.
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == OP_PUSH && !w_stat.full)
        |=> !w_stat.empty)
        else $error("stored character did not reach the line");

    // An end of a non-empty line starts a drain and empties the line.
    a_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == OP_END && !w_stat.empty)
        |=> (w_stat.draining && w_stat.empty))
        else $error("end of line did not start a drain");

    // A kill always leaves an empty line.
    a_kill_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == OP_KILL) |=> w_stat.empty)
        else $error("kill left characters in the line");
`endif

endmodule

// ===== tb/sv/line_edit_buffer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_edit_buffer_top. It drives characters on the input
// stream, predicts every edited line and checks each emitted character on the output.
// Depends on leb_pkg and the line edit buffer RTL.
module line_edit_buffer_top_tb;
    import leb_pkg::*;

    localparam int DEPTH        = LINE_DEPTH_DEF;
    // A drain of a full line plus the command queue, with margin to spare.
    localparam int QUIET_CYCLES = 120;
    // Worst case is every item draining a full line with each character held
    // by the longest output stall; the limit is a few times that.
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int N_DIR        = 22;

    // One emitted character as it appears on the output stream.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } t_line_char;

    // One row of the directed table. Rows with typed set carry their expected
    // output by hand; all other rows are checked against the line predictor.
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic       has_res;
        t_line_char res;
    } t_dir_row;

    // The table runs with the reset codes: erase 0x23, kill 0x40, end 0x0a.
    // The stop code is left for the very end, since it ends the session.
    localparam t_dir_row DIR_ROWS [0:N_DIR-1] = '{
        '{ERASE_RST, 1'b1, 1'b0, {8'h00, 1'b0, 1'b0}},  // erase on an empty line
        '{END_RST,   1'b1, 1'b0, {8'h00, 1'b0, 1'b0}},  // end of an empty line
        '{8'h00,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{8'hff,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{END_RST,   1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{8'h41,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{8'h42,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{ERASE_RST, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{8'h43,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{END_RST,   1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{8'h58,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{8'h59,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{KILL_RST,  1'b1, 1'b0, {8'h00, 1'b0, 1'b0}},  // kill drops X and Y
        '{8'h51,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{END_RST,   1'b1, 1'b1, {8'h51, 1'b1, 1'b0}},  // only Q is left
        '{8'h55,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{8'haa,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{ERASE_RST, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{ERASE_RST, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{ERASE_RST, 1'b1, 1'b0, {8'h00, 1'b0, 1'b0}},  // erase past the start
        '{8'h5a,     1'b0, 1'b0, {8'h00, 1'b0, 1'b0}},
        '{END_RST,   1'b1, 1'b1, {8'h5a, 1'b1, 1'b0}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;    // [7:0] out_char
    logic        m_axis_tlast;
    logic        m_axis_tuser;    // [0] line_truncated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: the four character codes and the line being edited.
    logic [7:0]  code_erase;
    logic [7:0]  code_kill;
    logic [7:0]  code_stop;
    logic [7:0]  code_end;
    logic [7:0]  line_buf [DEPTH];
    int          line_len;
    bit          stop_pending;
    bit          session_done;
    bit          line_clipped;

    // Characters predicted but not yet seen on the output, oldest first.
    t_line_char  chars_due [$];

    int          n_errors    = 0;
    int          cycle_count = 0;
    bit          tx_burst    = 1'b0;
    int          rx_left     = 0;
    bit          rx_ready    = 1'b0;

    line_edit_buffer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one accepted character to the predicted line. The end code is
    // tested first, then erase, kill and stop, so shared codes resolve the
    // same way as in the block. With emit clear the state still advances but
    // the expected output is supplied by the caller.
    function automatic void edit_line_char(input logic [7:0] ch, input bit emit);
        t_line_char c;
        int         k;
        if (session_done)
            return;
        if (ch == code_end) begin
            for (k = 0; k < line_len; k++) begin
                c.ch    = line_buf[k];
                c.last  = (k == line_len - 1);
                c.trunc = line_clipped;
                if (emit)
                    chars_due.push_back(c);
            end
            // An empty line with stop pending still ends the session.
            if (stop_pending)
                session_done = 1'b1;
            line_len     = 0;
            line_clipped = 1'b0;
            stop_pending = 1'b0;
        end else if (ch == code_erase) begin
            if (line_len > 0)
                line_len--;
        end else if (ch == code_kill) begin
            // Kill forgets a truncation but keeps a pending stop.
            line_len     = 0;
            line_clipped = 1'b0;
        end else if (ch == code_stop) begin
            stop_pending = 1'b1;
        end else if (line_len < DEPTH) begin
            line_buf[line_len] = ch;
            line_len++;
        end else begin
            line_clipped = 1'b1;
        end
    endfunction

    // True when a character would be taken as the stop code. Random traffic
    // avoids these until the last phase, since a halted block stays halted.
    function automatic bit hits_stop(input logic [7:0] ch);
        return ch == code_stop && ch != code_end && ch != code_erase && ch != code_kill;
    endfunction

    // Codes that end or edit a line; plain lines avoid them so they can fill up.
    function automatic bit is_special(input logic [7:0] ch);
        return ch == code_end || ch == code_erase || ch == code_kill || ch == code_stop;
    endfunction

    // Idle cycles before the next input request: mostly none, a few long.
    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_burst || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    // Presents one character and holds it until the block takes the request.
    // tvalid stays high on return, so a following call with no gap streams
    // back to back; callers that pause use hold_off first.
    task automatic send_char(input logic [7:0] ch, input int gap, input bit emit = 1'b1);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        edit_line_char(ch, emit);
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Stops the sender, waits for every predicted character and then lets the
    // block settle, since edits that emit nothing may still be in its queue.
    task automatic wait_drained();
        hold_off();
        while (chars_due.size() > 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the upper data bits carry junk that the
    // 8-bit registers must ignore.
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ERASE: code_erase = val;
            REG_KILL:  code_kill  = val;
            REG_STOP:  code_stop  = val;
            REG_END:   code_end   = val;
            default: ;
        endcase
    endtask

    task automatic set_codes(input logic [7:0] erase_v, input logic [7:0] kill_v,
                             input logic [7:0] stop_v, input logic [7:0] end_v);
        wait_drained();
        reg_write(REG_ERASE, erase_v);
        reg_write(REG_KILL, kill_v);
        reg_write(REG_STOP, stop_v);
        reg_write(REG_END, end_v);
    endtask

    // Random lines under the current codes. The first line fills the store to
    // about its depth so the boundary and truncation are usually reached;
    // after that most lines are short and noisy, a few long enough to overflow.
    task automatic run_lines(input int n_items);
        int         sent;
        int         lines;
        int         len;
        int         r;
        int         k;
        bit         plain;
        logic [7:0] ch;
        sent  = 0;
        lines = 0;
        while (sent < n_items) begin
            r     = $urandom_range(0, 99);
            plain = 1'b0;
            if (lines == 0) begin
                len   = DEPTH - 1 + $urandom_range(0, 4);
                plain = 1'b1;
            end else if (r < 70) begin
                len = $urandom_range(0, 6);
            end else if (r < 92) begin
                len = $urandom_range(7, 24);
            end else begin
                len   = $urandom_range(58, 76);
                plain = ($urandom_range(0, 9) < 7);
            end
            tx_burst = ($urandom_range(0, 4) == 0);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (!plain && r < 8) begin
                    ch = code_erase;
                end else if (!plain && r < 11) begin
                    ch = code_kill;
                end else begin
                    ch = 8'($urandom);
                    while (hits_stop(ch) || (plain && is_special(ch)))
                        ch = 8'($urandom);
                end
                send_char(ch, tx_gap());
                sent++;
            end
            // A kill after a full line must clear the truncation flag.
            if (lines == 0 && $urandom_range(0, 1) == 1) begin
                send_char(code_kill, tx_gap());
                send_char(8'($urandom_range(0, 255)) & 8'h00 | 8'h5e, tx_gap());
                sent += 2;
            end
            send_char(code_end, tx_gap());
            sent++;
            lines++;
            // Now and then let the output side empty out completely.
            if (lines % 12 == 0) begin
                hold_off();
                while (chars_due.size() > 0)
                    @(posedge i_clk);
            end
        end
        tx_burst = 1'b0;
    endtask

    // Last line of the session: a stop code, sometimes on an empty line and
    // sometimes with a kill in between, then traffic that must all be ignored.
    task automatic end_session();
        int         k;
        int         n;
        bit         full_line;
        logic [7:0] ch;
        full_line = 1'($urandom_range(0, 1));
        n = full_line ? $urandom_range(1, 6) : 0;
        for (k = 0; k < n; k++) begin
            ch = 8'($urandom);
            while (is_special(ch))
                ch = 8'($urandom);
            send_char(ch, tx_gap());
        end
        if (full_line && $urandom_range(0, 1) == 1)
            send_char(code_kill, tx_gap());
        send_char(code_stop, tx_gap());
        if (full_line)
            send_char(8'h7e, tx_gap());
        send_char(code_end, tx_gap());
        for (k = 0; k < 12; k++) begin
            if (k % 3 == 2)
                ch = code_end;
            else if (k == 4)
                ch = code_stop;
            else
                ch = 8'($urandom);
            send_char(ch, tx_gap());
        end
    endtask

    // Output pacing: ready stretches of varying length, short stalls and the
    // occasional long one.
    always @(negedge i_clk) begin : rx_pace
        int r;
        if (rx_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                rx_ready = 1'b1;
                rx_left  = $urandom_range(20, 60);
            end else if (r < 70) begin
                rx_ready = 1'b1;
                rx_left  = $urandom_range(1, 8);
            end else if (r < 95) begin
                rx_ready = 1'b0;
                rx_left  = $urandom_range(1, 3);
            end else begin
                rx_ready = 1'b0;
                rx_left  = $urandom_range(10, 40);
            end
        end
        rx_left--;
        m_axis_tready <= rx_ready;
    end

    // Every accepted output request is matched against the oldest prediction.
    always @(posedge i_clk) begin : out_check
        t_line_char want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (chars_due.size() == 0) begin
                report_mismatch($sformatf("unexpected character %02h", m_axis_tdata));
            end else begin
                want = chars_due.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_mismatch($sformatf("out_char %02h, want %02h",
                                              m_axis_tdata, want.ch));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("line_last %b, want %b on %02h",
                                              m_axis_tlast, want.last, want.ch));
                if (m_axis_tuser !== want.trunc)
                    report_mismatch($sformatf("line_truncated %b, want %b on %02h",
                                              m_axis_tuser, want.trunc, want.ch));
            end
        end
    end

    // Guards against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("line_edit_buffer_top_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int       i;
        t_dir_row row;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        code_erase    = ERASE_RST;
        code_kill     = KILL_RST;
        code_stop     = STOP_RST;
        code_end      = END_RST;
        line_len      = 0;
        stop_pending  = 1'b0;
        session_done  = 1'b0;
        line_clipped  = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed rows under the reset codes.
        for (i = 0; i < N_DIR; i++) begin
            row = DIR_ROWS[i];
            send_char(row.ch, tx_gap(), !row.typed);
            if (row.typed && row.has_res)
                chars_due.push_back(row.res);
        end

        run_lines(80);

        // Code extremes at both ends of the range.
        set_codes(8'h00, 8'hff, 8'h01, 8'hfe);
        run_lines(80);
        set_codes(8'hff, 8'h80, 8'h7f, 8'h00);
        run_lines(80);

        // All codes equal: end of line wins over everything.
        set_codes(8'h20, 8'h20, 8'h20, 8'h20);
        run_lines(60);

        // Erase shadows kill and stop.
        set_codes(8'h61, 8'h61, 8'h61, 8'h0d);
        run_lines(60);

        // Back to the reset codes, then the line that ends the session.
        set_codes(ERASE_RST, KILL_RST, STOP_RST, END_RST);
        run_lines(40);
        end_session();

        wait_drained();
        if (n_errors == 0)
            $display("line_edit_buffer_top_tb: PASS");
        else
            $display("line_edit_buffer_top_tb: FAIL");
        $finish;
    end

endmodule
